>>> rtl/page_table_window_manager_defines.svh
// Assertion macros for the page table window manager.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef PAGE_TABLE_WINDOW_MANAGER_DEFINES_SVH
`define PAGE_TABLE_WINDOW_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define PGTW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define PGTW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGTW_ASSERT(label, clk, rst_n, prop, msg)
`define PGTW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/pgtw_pkg.sv
// Shared types and constants of the page table window manager.
// No dependencies; imported by pgtw_ctrl and the top level.
package pgtw_pkg;

    // Default table depth
    localparam int ENTRIES_DEF = 1024;

    // Window and entry layout
    localparam logic [31:0] WIN_BASE       = 32'hC000_0000;
    localparam logic [11:0] BIT_PRESENT    = 12'h001;
    localparam logic [11:0] BIT_WRITE      = 12'h002;
    localparam logic [9:0]  HEAP_START_RST = 10'd768;

    // Request codes
    localparam logic [2:0] OP_MAP        = 3'd0;
    localparam logic [2:0] OP_UNMAP      = 3'd1;
    localparam logic [2:0] OP_QUERY      = 3'd2;
    localparam logic [2:0] OP_TEMP_MAP   = 3'd3;
    localparam logic [2:0] OP_TEMP_UNMAP = 3'd4;
    localparam logic [2:0] OP_CLEAR_HEAP = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_USED    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Invalidation kinds
    localparam logic [1:0] FL_NONE = 2'd0;
    localparam logic [1:0] FL_PAGE = 2'd1;
    localparam logic [1:0] FL_HEAP = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] lin_addr;
        logic [31:0] frame_addr;
        logic [11:0] flags;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        mapped;
        logic [1:0]  flush_kind;
        logic [31:0] flush_addr;
    } t_out_word;

endpackage

>>> rtl/pgtw_mem.sv
// Page table storage: one write port, one read port, registered read data.
// Depends on nothing but its ENTRIES parameter.
module pgtw_mem #(
    parameter int ENTRIES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  logic [31:0]                i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic [31:0]                o_rdata
);
    logic [31:0] r_mem [ENTRIES];
    logic [31:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pgtw_ctrl.sv
// Request sequencer: reset clearing pass, decode, table read-modify-write, heap walk, result register.
// Depends on pgtw_pkg and drives the ports of pgtw_mem.
`include "page_table_window_manager_defines.svh"

module pgtw_ctrl #(
    parameter int ENTRIES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pgtw_pkg::t_in_word         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pgtw_pkg::t_out_word        o_out,
    input  logic [9:0]                 i_heap_start,
    output logic                       o_we,
    output logic [$clog2(ENTRIES)-1:0] o_waddr,
    output logic [31:0]                o_wdata,
    output logic                       o_re,
    output logic [$clog2(ENTRIES)-1:0] o_raddr,
    input  logic [31:0]                i_rdata
);
    import pgtw_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] TEMP_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] LAST_HEAP = IDX_W'(ENTRIES - 2);
    localparam logic [19:0]      TEMP_PAGE = 20'(ENTRIES - 1);
    localparam logic [12:0]      TEMP_W13  = 13'(ENTRIES - 1);
    localparam logic [31:0]      TEMP_ADDR = WIN_BASE + (32'(ENTRIES - 1) << 12);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_EXEC = 5'b00100,
        S_WALK = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    t_in_word         r_req;
    logic             r_slot_ok;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_out_word        r_res, n_res;
    t_out_word        r_out;
    logic             r_out_valid, n_out_valid;

    logic             in_accept;
    logic [31:0]      in_off;
    logic [19:0]      in_page;
    logic             in_slot_ok;
    logic             out_free;
    logic             load_out;
    t_out_word        load_word;
    logic             heap_ok;
    logic [12:0]      heap_w13;
    logic             ex_we;
    logic [IDX_W-1:0] ex_waddr;
    logic [31:0]      ex_wdata;

    // Decode the incoming address into a table slot
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_off     = i_in.lin_addr - WIN_BASE;
    assign in_page    = in_off[31:12];
    assign in_slot_ok = (i_in.lin_addr[11:0] == 12'h000)
                        && (i_in.lin_addr >= WIN_BASE)
                        && (in_page < TEMP_PAGE);

    assign o_in_stall = (r_state != S_IDLE);
    assign o_re       = in_accept;
    assign o_raddr    = in_off[IDX_W+11:12];

    // Heap range check
    assign heap_w13 = 13'(i_heap_start);
    assign heap_ok  = (heap_w13 < TEMP_W13);

    // Work out the result and the table update of the held request
    always_comb begin
        n_res      = '0;
        ex_we      = 1'b0;
        ex_waddr   = r_slot;
        ex_wdata   = '0;
        case (r_req.op)
            OP_MAP: begin
                if ((r_req.frame_addr[11:0] != 12'h000) || !r_slot_ok) begin
                    n_res.status = ST_INVALID;
                end else if (i_rdata[0]) begin
                    n_res.status = ST_USED;
                end else begin
                    ex_we            = 1'b1;
                    ex_wdata         = {r_req.frame_addr[31:12], r_req.flags | BIT_PRESENT};
                    n_res.flush_kind = FL_PAGE;
                    n_res.flush_addr = r_req.lin_addr;
                end
            end
            OP_UNMAP: begin
                if (!r_slot_ok) begin
                    n_res.status = ST_INVALID;
                end else if (!i_rdata[0]) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    ex_we            = 1'b1;
                    n_res.flush_kind = FL_PAGE;
                    n_res.flush_addr = r_req.lin_addr;
                end
            end
            OP_QUERY: begin
                n_res.mapped = r_slot_ok && i_rdata[0];
            end
            OP_TEMP_MAP: begin
                ex_we            = 1'b1;
                ex_waddr         = TEMP_IDX;
                ex_wdata         = {r_req.frame_addr[31:12], BIT_PRESENT | BIT_WRITE};
                n_res.flush_kind = FL_PAGE;
                n_res.flush_addr = TEMP_ADDR;
            end
            OP_TEMP_UNMAP: begin
                ex_we            = 1'b1;
                ex_waddr         = TEMP_IDX;
                n_res.flush_kind = FL_PAGE;
                n_res.flush_addr = TEMP_ADDR;
            end
            OP_CLEAR_HEAP: begin
                if (heap_ok) begin
                    n_res.flush_kind = FL_HEAP;
                    n_res.flush_addr = WIN_BASE + (32'(i_heap_start) << 12);
                end
            end
            default: begin
                n_res.status = ST_INVALID;
            end
        endcase
    end

    // Memory write port: clearing pass, heap walk or single-entry update
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_idx;
        o_wdata = '0;
        case (r_state)
            S_CLR, S_WALK: begin
                o_we = 1'b1;
            end
            S_EXEC: begin
                o_we    = ex_we;
                o_waddr = ex_waddr;
                o_wdata = ex_wdata;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    // Sequencer
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        load_out  = 1'b0;
        load_word = r_res;
        case (r_state)
            S_CLR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == TEMP_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((r_req.op == OP_CLEAR_HEAP) && heap_ok) begin
                    n_idx   = heap_w13[IDX_W-1:0];
                    n_state = S_WALK;
                end else if (out_free) begin
                    load_out  = 1'b1;
                    load_word = n_res;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WALK: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_HEAP) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = load_out ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the request, the result and the output word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req     <= i_in;
            r_slot_ok <= in_slot_ok;
            r_slot    <= in_off[IDX_W+11:12];
        end
        if (r_state == S_EXEC) begin
            r_res <= n_res;
        end
        if (load_out) begin
            r_out <= load_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PGTW_ASSERT(a_no_write_on_accept, i_clk, i_rst_n, in_accept |-> !o_we, "write during accept")
    `PGTW_ASSERT(a_accept_to_exec, i_clk, i_rst_n, in_accept |=> (r_state == S_EXEC), "no exec")
    `PGTW_ASSERT(a_walk_temp, i_clk, i_rst_n, r_state == S_WALK |-> r_idx != TEMP_IDX, "temp hit")
    `PGTW_ASSERT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_out_stall |=> r_out_valid, "lost")

endmodule

>>> rtl/page_table_window_manager.sv
// Top level of the page table window manager: heap start register, sequencer, table.
// Depends on pgtw_pkg, pgtw_ctrl and pgtw_mem.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+-------------------------
//   request  | in        | i_in_valid / o_in_stall | op, addresses, flags
//   result   | out       | o_out_valid / i_out_stall | status, flush info
//   config   | in        | i_cfg_valid / o_cfg_ready | heap_start_index
//
// A single-entry request is accepted with its table read in S_IDLE, then
// updated with its result loaded in S_EXEC. If the previous result is still
// stalled at update, the request waits in S_FIN until that result leaves.
// Heap clear zeroes ENTRIES - 1 - heap_start_index entries in S_WALK, then loads the result.
// After reset the table is zeroed one entry per cycle; requests stall until all are clear.
// Configuration writes are taken in every cycle outside reset.
module page_table_window_manager #(
    parameter int ENTRIES = pgtw_pkg::ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pgtw_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pgtw_pkg::t_out_word o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [9:0]          i_cfg_data
);
    import pgtw_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic [9:0]       r_heap_start;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic [31:0]      rdata;

    // Heap start register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= HEAP_START_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_heap_start <= i_cfg_data;
        end
    end

    pgtw_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out),
        .i_heap_start (r_heap_start),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    pgtw_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
